### src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and constants for the quaternion to Euler bin pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QW          = 16;  // quaternion component width
  localparam int PW          = 32;  // product width
  localparam int SW          = 35;  // Q28 sum width
  localparam int RW          = 29;  // square root result width
  localparam int NW          = 59;  // square root remainder width
  localparam int CW          = 38;  // CORDIC vector width
  localparam int AW          = 18;  // CORDIC angle accumulator width
  localparam int STEPS       = 15;  // CORDIC iterations
  localparam int ONE_SHIFT   = 28;  // 1.0 in Q28
  localparam int OW          = 5;   // bin field width

  localparam logic signed [SW-1:0] ONE_Q28  = SW'(64'sd1 <<< ONE_SHIFT);
  localparam logic signed [AW-1:0] QUARTER  = AW'(16384);

  typedef struct packed {
    logic signed [SW-1:0] rn;
    logic signed [SW-1:0] rd;
    logic signed [SW-1:0] ps;
    logic signed [SW-1:0] yn;
    logic signed [SW-1:0] yd;
  } side_t;

  // full circle: pos = zero numerator with non-negative denominator, neg = angle pi
  // half circle: pos = argument at or above +1, neg = argument at or below -1
  typedef struct packed {
    logic pos;
    logic neg;
  } special_t;

  function automatic logic [13:0] atan_turns(input int i);
    logic [13:0] r;
    case (i)
      0:       r = 14'd8192;
      1:       r = 14'd4836;
      2:       r = 14'd2555;
      3:       r = 14'd1297;
      4:       r = 14'd651;
      5:       r = 14'd326;
      6:       r = 14'd163;
      7:       r = 14'd81;
      8:       r = 14'd41;
      9:       r = 14'd20;
      10:      r = 14'd10;
      11:      r = 14'd5;
      12:      r = 14'd3;
      13:      r = 14'd1;
      14:      r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

### src/qte_if.sv
// ----------------------------------------------------------------------------
// qte_in_if / qte_out_if
// Valid/ready channels for quaternion input and Euler bin output.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] roll_bin;
  logic [4:0] pitch_bin;
  logic [4:0] yaw_bin;

  modport source (output valid, roll_bin, pitch_bin, yaw_bin, input ready);
  modport sink   (input valid, roll_bin, pitch_bin, yaw_bin, output ready);
endinterface

### src/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Two stages: component products, then the Q28 atan2/asin arguments.
// ----------------------------------------------------------------------------
module qte_front
  import qte_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic signed [QW-1:0] w_i,
  input  logic signed [QW-1:0] x_i,
  input  logic signed [QW-1:0] y_i,
  input  logic signed [QW-1:0] z_i,
  output logic                 vld_o,
  output side_t                side_o
);

  logic                 v1_q, v2_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  side_t                side_q, side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wx_q   <= w_i * x_i;
      yz_q   <= y_i * z_i;
      xx_q   <= x_i * x_i;
      yy_q   <= y_i * y_i;
      wy_q   <= w_i * y_i;
      zx_q   <= z_i * x_i;
      wz_q   <= w_i * z_i;
      xy_q   <= x_i * y_i;
      zz_q   <= z_i * z_i;
      side_q <= side_d;
    end
  end

  always_comb begin
    side_d.rn = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    side_d.rd = ONE_Q28 - ((SW'(xx_q) + SW'(yy_q)) <<< 1);
    side_d.ps = (SW'(wy_q) - SW'(zx_q)) <<< 1;
    side_d.yn = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    side_d.yd = ONE_Q28 - ((SW'(yy_q) + SW'(zz_q)) <<< 1);
  end

  assign vld_o  = v2_q;
  assign side_o = side_q;

endmodule

### src/qte_sqrt.sv
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined cosine of the pitch argument: floor(sqrt(2^56 - s^2)), one root
// bit per stage, with the remaining arguments carried alongside.
// ----------------------------------------------------------------------------
module qte_sqrt
  import qte_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          vld_i,
  input  side_t         side_i,
  output logic          vld_o,
  output logic [RW-1:0] root_o,
  output side_t         side_o
);

  logic                 vld_q  [0:RW];
  logic [NW-1:0]        rem_q  [0:RW];
  logic [RW-1:0]        root_q [0:RW];
  side_t                side_q [0:RW];
  logic signed [SW-1:0] s_abs;
  logic [27:0]          mag;
  logic [55:0]          sq;

  assign s_abs = side_i.ps[SW-1] ? -side_i.ps : side_i.ps;
  assign mag   = s_abs[27:0];
  assign sq    = mag * mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= (NW'(1) << 56) - NW'(sq);
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int K = RW - 1 - j;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = (NW'(root_q[j]) << (K + 1)) + (NW'(1) << (2 * K));
    assign take  = rem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j+1]  <= take ? rem_q[j] - trial : rem_q[j];
        root_q[j+1] <= take ? (root_q[j] | (RW'(1) << K)) : root_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign side_o = side_q[RW];

endmodule

### src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC, one iteration per stage, angle in 2^-16 turn.
// A quarter-turn pre-rotation brings left half plane vectors over first.
// ----------------------------------------------------------------------------
module qte_cordic
  import qte_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  special_t             spec_i,
  output logic                 vld_o,
  output logic signed [AW-1:0] ang_o,
  output special_t             spec_o
);

  logic                 vld_q  [0:STEPS];
  logic signed [CW-1:0] x_q    [0:STEPS];
  logic signed [CW-1:0] y_q    [0:STEPS];
  logic signed [AW-1:0] a_q    [0:STEPS];
  special_t             spec_q [0:STEPS];
  logic signed [CW-1:0] x0_d, y0_d;
  logic signed [AW-1:0] a0_d;

  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    a0_d = '0;
    if (x_i[CW-1]) begin
      if (!y_i[CW-1]) begin
        x0_d = y_i;
        y0_d = -x_i;
        a0_d = QUARTER;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        a0_d = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      a_q[0]    <= a0_d;
      spec_q[0] <= spec_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [AW-1:0] T = AW'(atan_turns(i));
    logic signed [CW-1:0] xs, ys;
    logic                 up;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign up = !y_q[i][CW-1] && (|y_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i+1]    <= up ? x_q[i] + ys : x_q[i] - ys;
        y_q[i+1]    <= up ? y_q[i] - xs : y_q[i] + xs;
        a_q[i+1]    <= up ? a_q[i] + T : a_q[i] - T;
        spec_q[i+1] <= spec_q[i];
      end
    end
  end

  assign vld_o  = vld_q[STEPS];
  assign ang_o  = a_q[STEPS];
  assign spec_o = spec_q[STEPS];

endmodule

### src/qte_bin.sv
// ----------------------------------------------------------------------------
// qte_bin
// Offsets, clamps and scales the three angles to bins; output register.
// ----------------------------------------------------------------------------
module qte_bin
  import qte_pkg::*;
#(
  parameter int ANGLE_BINS = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic signed [AW-1:0] roll_ang_i,
  input  special_t             roll_spec_i,
  input  logic signed [AW-1:0] pitch_ang_i,
  input  special_t             pitch_spec_i,
  input  logic signed [AW-1:0] yaw_ang_i,
  input  special_t             yaw_spec_i,
  output logic                 vld_o,
  output logic [OW-1:0]        roll_o,
  output logic [OW-1:0]        pitch_o,
  output logic [OW-1:0]        yaw_o
);

  localparam int BNW = $clog2(ANGLE_BINS + 1);
  localparam int FPW = 16 + BNW + OW;
  localparam int HPW = 15 + BNW + OW;
  localparam logic [BNW-1:0] BINS     = BNW'(ANGLE_BINS);
  localparam logic [OW-1:0]  BINS_OUT = OW'(ANGLE_BINS);

  logic          vld_q;
  logic [OW-1:0] roll_q, pitch_q, yaw_q;
  logic [OW-1:0] roll_d, pitch_d, yaw_d;

  function automatic logic [OW-1:0] full_bin(input logic signed [AW-1:0] a,
                                             input special_t sp);
    logic signed [AW:0] u;
    logic [15:0]        uc;
    logic [FPW-1:0]     p;
    u  = (AW+1)'(a) + (AW+1)'(32768);
    if (u[AW])             uc = '0;
    else if (u > 65535)    uc = 16'hFFFF;
    else                   uc = u[15:0];
    if (sp.pos)            uc = 16'h8000;
    p = FPW'(uc) * FPW'(BINS);
    return sp.neg ? BINS_OUT : p[16 +: OW];
  endfunction

  always_comb begin
    logic signed [AW:0] u;
    logic [14:0]        uc;
    logic [HPW-1:0]     p;
    roll_d = full_bin(roll_ang_i, roll_spec_i);
    yaw_d  = full_bin(yaw_ang_i, yaw_spec_i);
    u = (AW+1)'(pitch_ang_i) + (AW+1)'(16384);
    if (u[AW])           uc = '0;
    else if (u > 32767)  uc = 15'h7FFF;
    else                 uc = u[14:0];
    p = HPW'(uc) * HPW'(BINS);
    if (pitch_spec_i.pos)      pitch_d = BINS_OUT;
    else if (pitch_spec_i.neg) pitch_d = '0;
    else                       pitch_d = p[15 +: OW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign vld_o   = vld_q;
  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign yaw_o   = yaw_q;

endmodule

### src/quaternion_to_euler_bins.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins
// Unit quaternion (Q1.14) to quantized roll, pitch and yaw bins.
//
// quat_i takes one quaternion per transfer (w, x, y, z, signed Q1.14).
// euler_o gives one transfer per quaternion: roll_bin and yaw_bin from a
// full-circle atan2, pitch_bin from a clamped asin, each in 0..ANGLE_BINS.
// Stages, in order: products and sums, the bit-per-stage square root of
// the pitch cosine, the CORDIC (quarter-turn pre-rotation plus 15
// iterations), and binning into the output register. One quaternion per
// cycle enters while euler_o is not stalled; the square root stages set the
// depth. All stages advance together: when euler_o holds a transfer and
// its ready is low, the whole pipeline and quat_i.ready stall, and nothing
// is dropped or repeated. Reset clears only the valid bits; the data
// registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_bins
  import qte_pkg::*;
#(
  parameter int ANGLE_BINS = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qte_in_if.sink     quat_i,
  qte_out_if.source  euler_o
);

  logic                 adv;
  logic                 f_vld, s_vld, c_vld, p_vld, y_vld, b_vld;
  side_t                f_side, s_side;
  logic [RW-1:0]        s_root;
  special_t             r_spec, p_spec, y_spec;
  special_t             r_spec_o, p_spec_o, y_spec_o;
  logic signed [AW-1:0] r_ang, p_ang, y_ang;

  assign adv          = !b_vld || euler_o.ready;
  assign quat_i.ready = adv;
  assign euler_o.valid = b_vld;

  qte_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (quat_i.valid),
    .w_i    (quat_i.quat_w),
    .x_i    (quat_i.quat_x),
    .y_i    (quat_i.quat_y),
    .z_i    (quat_i.quat_z),
    .vld_o  (f_vld),
    .side_o (f_side)
  );

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (f_vld),
    .side_i (f_side),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  always_comb begin
    r_spec.pos = (s_side.rn == '0) && !s_side.rd[SW-1];
    r_spec.neg = (s_side.rn == '0) && s_side.rd[SW-1];
    y_spec.pos = (s_side.yn == '0) && !s_side.yd[SW-1];
    y_spec.neg = (s_side.yn == '0) && s_side.yd[SW-1];
    p_spec.pos = s_side.ps >= ONE_Q28;
    p_spec.neg = s_side.ps <= -ONE_Q28;
  end

  qte_cordic u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_vld),
    .x_i    (CW'(s_side.rd)),
    .y_i    (CW'(s_side.rn)),
    .spec_i (r_spec),
    .vld_o  (c_vld),
    .ang_o  (r_ang),
    .spec_o (r_spec_o)
  );

  qte_cordic u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_vld),
    .x_i    (signed'(CW'(s_root))),
    .y_i    (CW'(s_side.ps)),
    .spec_i (p_spec),
    .vld_o  (p_vld),
    .ang_o  (p_ang),
    .spec_o (p_spec_o)
  );

  qte_cordic u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_vld),
    .x_i    (CW'(s_side.yd)),
    .y_i    (CW'(s_side.yn)),
    .spec_i (y_spec),
    .vld_o  (y_vld),
    .ang_o  (y_ang),
    .spec_o (y_spec_o)
  );

  qte_bin #(
    .ANGLE_BINS (ANGLE_BINS)
  ) u_bin (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .vld_i        (c_vld && p_vld && y_vld),
    .roll_ang_i   (r_ang),
    .roll_spec_i  (r_spec_o),
    .pitch_ang_i  (p_ang),
    .pitch_spec_i (p_spec_o),
    .yaw_ang_i    (y_ang),
    .yaw_spec_i   (y_spec_o),
    .vld_o        (b_vld),
    .roll_o       (euler_o.roll_bin),
    .pitch_o      (euler_o.pitch_bin),
    .yaw_o        (euler_o.yaw_bin)
  );

endmodule
